// ----- hw/rtl/lfum_pkg.sv -----
// Shared types, constants and elaboration-time tables for the link flap uptime metric.
package lfum_pkg;

  // Ring geometry.
  localparam int HistDepth = 16;
  localparam int HistAw = 4;
  localparam int CntW = 5;

  // Data widths.
  localparam int TimeW = 48;
  localparam int FracW = 17;
  localparam int QuotW = 33;
  localparam int RemW = TimeW + 1;
  localparam int StepW = 6;

  // Exponential weight constants.
  localparam int QBits = 10;
  localparam logic [QBits-1:0] QSat = 10'd1023;
  localparam logic [63:0] OneQ62 = 64'h4000_0000_0000_0000;
  localparam logic [FracW-1:0] FracOne = 17'd65536;

  // Terms of the alternating series for exp(-1/64) in Q2.62; term k is term k-1 over 64*k.
  localparam logic [63:0] ExpT1 = OneQ62 / 64'd64;
  localparam logic [63:0] ExpT2 = ExpT1 / 64'd128;
  localparam logic [63:0] ExpT3 = ExpT2 / 64'd192;
  localparam logic [63:0] ExpT4 = ExpT3 / 64'd256;
  localparam logic [63:0] ExpT5 = ExpT4 / 64'd320;
  localparam logic [63:0] ExpT6 = ExpT5 / 64'd384;
  localparam logic [63:0] ExpT7 = ExpT6 / 64'd448;
  localparam logic [63:0] ExpT8 = ExpT7 / 64'd512;
  localparam logic [63:0] ExpT9 = ExpT8 / 64'd576;
  localparam logic [63:0] ExpT10 = ExpT9 / 64'd640;
  localparam logic [63:0] ExpT11 = ExpT10 / 64'd704;
  localparam logic [63:0] ExpT12 = ExpT11 / 64'd768;
  localparam logic [63:0] ExpT13 = ExpT12 / 64'd832;
  localparam logic [63:0] ExpT14 = ExpT13 / 64'd896;
  localparam logic [63:0] ExpT15 = ExpT14 / 64'd960;

  // exp(-1/64) in Q2.62.
  localparam logic [63:0] ExpStepQ62 = OneQ62 - ExpT1 + ExpT2 - ExpT3 + ExpT4 - ExpT5
                                       + ExpT6 - ExpT7 + ExpT8 - ExpT9 + ExpT10 - ExpT11
                                       + ExpT12 - ExpT13 + ExpT14 - ExpT15;

  // Command codes.
  localparam logic [1:0] CmdInit = 2'd0;
  localparam logic [1:0] CmdToggle = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  // Configuration register indexes.
  localparam logic CfgFalloff = 1'b0;
  localparam logic CfgPower = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] FalloffReset = 16'd320;
  localparam logic [3:0] PowerReset = 4'd4;

  typedef struct packed {
    logic [1:0]       command;
    logic [TimeW-1:0] time_ms;
    logic             initial_up;
  } in_item_t;

  typedef struct packed {
    logic             link_up;
    logic [FracW-1:0] uptime_fraction;
    logic [FracW-1:0] weighted_uptime;
    logic [31:0]      damping_metric;
    logic [CntW-1:0]  history_count;
  } out_item_t;

  // Request to the shared shift-subtract divider.
  typedef struct packed {
    logic             start;
    logic [RemW-1:0]  rem_init;
    logic [QuotW-1:0] dividend;
    logic [StepW-1:0] steps;
    logic [TimeW-1:0] divisor;
  } div_req_t;

  // Q2.62 product, truncated, as used when the tables are built.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(-1/64) raised to 2^k by repeated squaring.
  function automatic logic [63:0] base_pow(input int k);
    logic [63:0] b;
    b = ExpStepQ62;
    for (int i = 0; i < k; i++) begin
      b = mul_q62(b, b);
    end
    return b;
  endfunction

  localparam logic [63:0] BasePow [QBits] = '{
    base_pow(0), base_pow(1), base_pow(2), base_pow(3), base_pow(4),
    base_pow(5), base_pow(6), base_pow(7), base_pow(8), base_pow(9)
  };

endpackage

// ----- hw/rtl/lfum_ring.sv -----
// Ring memory of toggle times with one write port and a registered read port.
module lfum_ring (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [lfum_pkg::HistAw-1:0] wr_addr,
  input  logic [lfum_pkg::TimeW-1:0]  wr_data,
  input  logic [lfum_pkg::HistAw-1:0] rd_addr,
  output logic [lfum_pkg::TimeW-1:0]  rd_data
);

  logic [lfum_pkg::TimeW-1:0] mem [lfum_pkg::HistDepth];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/lfum_div.sv -----
// Shared restoring divider that retires one quotient bit per cycle.
module lfum_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfum_pkg::div_req_t             req,
  output logic                           done,
  output logic [lfum_pkg::QuotW-1:0]     quot
);

  logic                           active_r;
  logic [lfum_pkg::StepW-1:0]     cnt_r;
  logic [lfum_pkg::RemW-1:0]      rem_r;
  logic [lfum_pkg::QuotW-1:0]     dvd_r;
  logic [lfum_pkg::QuotW-1:0]     quot_r;
  logic [lfum_pkg::TimeW-1:0]     dsr_r;
  logic [lfum_pkg::RemW-1:0]      trial;
  logic                           ge;

  // One shift-subtract step.
  always_comb begin
    trial = {rem_r[lfum_pkg::RemW-2:0], dvd_r[lfum_pkg::QuotW-1]};
    ge = trial >= {1'b0, dsr_r};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      active_r <= 1'b1;
      cnt_r <= req.steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? trial - {1'b0, dsr_r} : trial;
      dvd_r <= {dvd_r[lfum_pkg::QuotW-2:0], 1'b0};
      quot_r <= {quot_r[lfum_pkg::QuotW-2:0], ge};
    end
  end

  assign done = active_r && (cnt_r == '0);
  assign quot = quot_r;

endmodule

// ----- hw/rtl/link_flap_uptime_metric.sv -----
// Top level: command sequencer, shared multiplier and query datapath.
// Init, toggle and unused commands go to S_DONE, which loads the output register.
// A query walks the ring and evaluates up to sixteen exponential weights, each a
// divide plus up to ten multiplies on one 32x32 multiplier; busy falls in the cycle
// the result strobe rises. Synchronous reset clears the ring pointers, the link
// state, the state and strobe registers, and reloads the configuration registers.
module link_flap_uptime_metric (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lfum_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lfum_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_RD      = 25'h0000002,
    S_QSTART  = 25'h0000004,
    S_QTOT    = 25'h0000008,
    S_QWTOT   = 25'h0000010,
    S_QA0     = 25'h0000020,
    S_QWA0    = 25'h0000040,
    S_QTR     = 25'h0000080,
    S_QWTR    = 25'h0000100,
    S_QTL     = 25'h0000200,
    S_QWTL    = 25'h0000400,
    S_QCLAMP  = 25'h0000800,
    S_QDPL    = 25'h0001000,
    S_QDWS    = 25'h0002000,
    S_QPOW    = 25'h0004000,
    S_QMET    = 25'h0008000,
    S_QMETW   = 25'h0010000,
    S_DONE    = 25'h0020000,
    S_WSTART  = 25'h0040000,
    S_WDIV    = 25'h0080000,
    S_WEXP    = 25'h0100000,
    S_WBIT    = 25'h0200000,
    S_WMUL    = 25'h0400000,
    S_WMULD   = 25'h0800000,
    S_WFIN    = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  state_t rret_r, rret_nxt;

  // Configuration and ring bookkeeping.
  logic [15:0]                   falloff_r;
  logic [3:0]                    power_r;
  logic [lfum_pkg::HistAw-1:0]   wi_r, wi_nxt;
  logic [lfum_pkg::CntW-1:0]     cnt_r, cnt_nxt;
  logic                          full_r, full_nxt;
  logic                          up_r, up_nxt;

  // Query datapath.
  logic [lfum_pkg::TimeW-1:0]    now_r, now_nxt;
  logic [lfum_pkg::TimeW-1:0]    tot_r, tot_nxt;
  logic [lfum_pkg::TimeW-1:0]    age_r, age_nxt;
  logic [lfum_pkg::TimeW-1:0]    tr_r, tr_nxt;
  logic [51:0]                   s_r, s_nxt;
  logic signed [20:0]            ws_r, ws_nxt;
  logic [lfum_pkg::FracW-1:0]    wtot_r, wtot_nxt;
  logic [lfum_pkg::FracW-1:0]    plain_r, plain_nxt;
  logic [lfum_pkg::FracW-1:0]    wpow_r, wpow_nxt;
  logic [lfum_pkg::FracW-1:0]    x_r, x_nxt;
  logic [31:0]                   metric_r, metric_nxt;
  logic [3:0]                    m_r, m_nxt;
  logic [3:0]                    p_r, p_nxt;
  logic [lfum_pkg::HistAw-1:0]   rd_addr_r, rd_addr_nxt;

  // Weight unit.
  logic [lfum_pkg::QBits-1:0]    q_r, q_nxt;
  logic [3:0]                    k_r, k_nxt;
  logic [1:0]                    pp_r, pp_nxt;
  logic [63:0]                   v_r, v_nxt;
  logic [127:0]                  acc_r, acc_nxt;
  logic [lfum_pkg::FracW-1:0]    w_r, w_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  lfum_pkg::out_item_t           out_r, out_nxt;

  // Shared pieces.
  logic                          wr_en;
  logic [lfum_pkg::HistAw-1:0]   wr_addr;
  logic [lfum_pkg::TimeW-1:0]    rd_data;
  lfum_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [lfum_pkg::QuotW-1:0]    div_quot;
  logic [31:0]                   mul_a, mul_b;
  logic [63:0]                   mul_p;
  logic [127:0]                  pp_shifted;
  logic [63:0]                   base_sel;
  logic [lfum_pkg::TimeW-1:0]    rd_age;
  logic [lfum_pkg::CntW-1:0]     n_ent;
  logic [3:0]                    pairs;
  logic [15:0]                   f_eff;
  logic                          accept;
  logic [lfum_pkg::HistAw-1:0]   wi_base;
  logic [lfum_pkg::CntW-1:0]     cnt_base;
  logic                          full_base;
  logic signed [20:0]            ws_cl;
  logic [51:0]                   s_cl;
  logic [lfum_pkg::TimeW-1:0]    s_fin;
  logic [lfum_pkg::FracW-1:0]    ws_fin;
  logic [63:0]                   w_round;

  lfum_ring u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.time_ms),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  lfum_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Record bookkeeping for init and toggle transfers.
  always_comb begin
    wi_base = (in_data.command == lfum_pkg::CmdInit) ? '0 : wi_r;
    cnt_base = (in_data.command == lfum_pkg::CmdInit) ? '0 : cnt_r;
    full_base = (in_data.command == lfum_pkg::CmdInit) ? 1'b0 : full_r;
    wr_en = accept && ((in_data.command == lfum_pkg::CmdInit) ||
                       (in_data.command == lfum_pkg::CmdToggle));
    wr_addr = wi_base;
  end

  // Shared 32x32 multiplier, used by the weight unit and by the power loop.
  always_comb begin
    base_sel = lfum_pkg::BasePow[k_r];
    if (state_r == S_WMUL) begin
      mul_a = pp_r[0] ? v_r[63:32] : v_r[31:0];
      mul_b = pp_r[1] ? base_sel[63:32] : base_sel[31:0];
    end else begin
      mul_a = {15'd0, wpow_r};
      mul_b = {15'd0, x_r};
    end
    mul_p = mul_a * mul_b;
    case (pp_r)
      2'd0:    pp_shifted = {64'd0, mul_p};
      2'd3:    pp_shifted = {mul_p, 64'd0};
      default: pp_shifted = {32'd0, mul_p, 32'd0};
    endcase
  end

  // Helper values for the query walk.
  always_comb begin
    rd_age = (now_r >= rd_data) ? now_r - rd_data : '0;
    n_ent = cnt_r;
    pairs = 4'((n_ent - 1'b1) >> 1);
    f_eff = (falloff_r == '0) ? 16'd1 : falloff_r;
    s_cl = (s_r > {4'd0, tot_r}) ? {4'd0, tot_r} : s_r;
    if (ws_r < 0) begin
      ws_cl = '0;
    end else if (ws_r > $signed({4'd0, wtot_r})) begin
      ws_cl = $signed({4'd0, wtot_r});
    end else begin
      ws_cl = ws_r;
    end
    s_fin = up_r ? s_cl[lfum_pkg::TimeW-1:0] : tot_r - s_cl[lfum_pkg::TimeW-1:0];
    ws_fin = up_r ? ws_cl[lfum_pkg::FracW-1:0] : wtot_r - ws_cl[lfum_pkg::FracW-1:0];
    w_round = v_r + 64'h0000_2000_0000_0000;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    rret_nxt = rret_r;
    wi_nxt = wi_r;
    cnt_nxt = cnt_r;
    full_nxt = full_r;
    up_nxt = up_r;
    now_nxt = now_r;
    tot_nxt = tot_r;
    age_nxt = age_r;
    tr_nxt = tr_r;
    s_nxt = s_r;
    ws_nxt = ws_r;
    wtot_nxt = wtot_r;
    plain_nxt = plain_r;
    wpow_nxt = wpow_r;
    x_nxt = x_r;
    metric_nxt = metric_r;
    m_nxt = m_r;
    p_nxt = p_r;
    rd_addr_nxt = rd_addr_r;
    q_nxt = q_r;
    k_nxt = k_r;
    pp_nxt = pp_r;
    v_nxt = v_r;
    acc_nxt = acc_r;
    w_nxt = w_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    div_req = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt = in_data.time_ms;
          plain_nxt = '0;
          wpow_nxt = '0;
          metric_nxt = '0;
          if (wr_en) begin
            up_nxt = (in_data.command == lfum_pkg::CmdInit) ? in_data.initial_up : ~up_r;
            wi_nxt = wi_base + 1'b1;
            cnt_nxt = full_base ? cnt_base : cnt_base + 1'b1;
            full_nxt = full_base;
            if (wi_base + 1'b1 == '0) begin
              full_nxt = 1'b1;
              cnt_nxt = lfum_pkg::CntW'(lfum_pkg::HistDepth);
            end
          end
          state_nxt = (in_data.command == lfum_pkg::CmdQuery) ? S_QSTART : S_DONE;
        end
      end
      S_RD: begin
        state_nxt = rret_r;
      end
      S_QSTART: begin
        if (n_ent == '0) begin
          plain_nxt = up_r ? lfum_pkg::FracOne : '0;
          wpow_nxt = up_r ? lfum_pkg::FracOne : '0;
          state_nxt = S_QMET;
        end else begin
          rd_addr_nxt = wi_r - n_ent[lfum_pkg::HistAw-1:0];
          rret_nxt = S_QTOT;
          state_nxt = S_RD;
        end
      end
      S_QTOT: begin
        tot_nxt = rd_age;
        age_nxt = rd_age;
        ret_nxt = S_QWTOT;
        state_nxt = S_WSTART;
      end
      S_QWTOT: begin
        wtot_nxt = lfum_pkg::FracOne - w_r;
        if (n_ent <= 5'd1 || tot_r == '0 || w_r == lfum_pkg::FracOne) begin
          plain_nxt = up_r ? lfum_pkg::FracOne : '0;
          wpow_nxt = up_r ? lfum_pkg::FracOne : '0;
          state_nxt = S_QMET;
        end else begin
          rd_addr_nxt = wi_r - 1'b1;
          rret_nxt = S_QA0;
          state_nxt = S_RD;
        end
      end
      S_QA0: begin
        s_nxt = {4'd0, rd_age};
        age_nxt = rd_age;
        ret_nxt = S_QWA0;
        state_nxt = S_WSTART;
      end
      S_QWA0: begin
        ws_nxt = $signed({4'd0, lfum_pkg::FracOne - w_r});
        m_nxt = 4'd1;
        if (pairs == '0) begin
          state_nxt = S_QCLAMP;
        end else begin
          rd_addr_nxt = wi_r - 4'd2;
          rret_nxt = S_QTR;
          state_nxt = S_RD;
        end
      end
      S_QTR: begin
        tr_nxt = rd_data;
        age_nxt = rd_age;
        ret_nxt = S_QWTR;
        state_nxt = S_WSTART;
      end
      S_QWTR: begin
        ws_nxt = ws_r + $signed({4'd0, w_r});
        rd_addr_nxt = wi_r - 1'b1 - {m_r[2:0], 1'b0};
        rret_nxt = S_QTL;
        state_nxt = S_RD;
      end
      S_QTL: begin
        if (tr_r >= rd_data) begin
          s_nxt = s_r + {4'd0, tr_r - rd_data};
        end
        age_nxt = rd_age;
        ret_nxt = S_QWTL;
        state_nxt = S_WSTART;
      end
      S_QWTL: begin
        ws_nxt = ws_r - $signed({4'd0, w_r});
        m_nxt = m_r + 1'b1;
        if (m_r + 1'b1 > pairs) begin
          state_nxt = S_QCLAMP;
        end else begin
          rd_addr_nxt = wi_r - {m_r[2:0] + 3'd1, 1'b0};
          rret_nxt = S_QTR;
          state_nxt = S_RD;
        end
      end
      S_QCLAMP: begin
        ws_nxt = $signed({4'd0, ws_fin});
        div_req.start = 1'b1;
        div_req.rem_init = {2'd0, s_fin[lfum_pkg::TimeW-1:1]};
        div_req.dividend = {s_fin[0], 32'd0};
        div_req.steps = 6'd17;
        div_req.divisor = tot_r;
        state_nxt = S_QDPL;
      end
      S_QDPL: begin
        if (div_done) begin
          plain_nxt = div_quot[lfum_pkg::FracW-1:0];
          div_req.start = 1'b1;
          div_req.rem_init = {33'd0, ws_r[16:1]};
          div_req.dividend = {ws_r[0], 32'd0};
          div_req.steps = 6'd17;
          div_req.divisor = {31'd0, wtot_r};
          state_nxt = S_QDWS;
        end
      end
      S_QDWS: begin
        if (div_done) begin
          x_nxt = div_quot[lfum_pkg::FracW-1:0];
          wpow_nxt = lfum_pkg::FracOne;
          p_nxt = '0;
          state_nxt = S_QPOW;
        end
      end
      S_QPOW: begin
        if (p_r < power_r) begin
          wpow_nxt = mul_p[32:16];
          p_nxt = p_r + 1'b1;
        end else begin
          state_nxt = S_QMET;
        end
      end
      S_QMET: begin
        if (up_r) begin
          metric_nxt = 32'd65536;
          state_nxt = S_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = {1'b1, 32'd0};
          div_req.steps = 6'd33;
          div_req.divisor = {31'd0, wpow_r} + 48'd7;
          state_nxt = S_QMETW;
        end
      end
      S_QMETW: begin
        if (div_done) begin
          metric_nxt = div_quot[31:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt.link_up = up_r;
        out_nxt.uptime_fraction = plain_r;
        out_nxt.weighted_uptime = wpow_r;
        out_nxt.damping_metric = metric_r;
        out_nxt.history_count = cnt_r;
        state_nxt = S_IDLE;
      end
      // Weight of age_r: quantize by the falloff, then raise exp(-1/64) to q.
      S_WSTART: begin
        if (age_r >= {28'd0, f_eff, 4'd0}) begin
          q_nxt = lfum_pkg::QSat;
          state_nxt = S_WEXP;
        end else begin
          div_req.start = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = {7'd0, age_r[19:0], 6'd0};
          div_req.steps = 6'd33;
          div_req.divisor = {32'd0, f_eff};
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_done) begin
          q_nxt = div_quot[lfum_pkg::QBits-1:0];
          state_nxt = S_WEXP;
        end
      end
      S_WEXP: begin
        v_nxt = lfum_pkg::OneQ62;
        k_nxt = '0;
        state_nxt = S_WBIT;
      end
      S_WBIT: begin
        if (k_r == 4'(lfum_pkg::QBits)) begin
          state_nxt = S_WFIN;
        end else if (q_r[k_r]) begin
          acc_nxt = '0;
          pp_nxt = '0;
          state_nxt = S_WMUL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_WMUL: begin
        acc_nxt = acc_r + pp_shifted;
        pp_nxt = pp_r + 1'b1;
        if (pp_r == 2'd3) begin
          state_nxt = S_WMULD;
        end
      end
      S_WMULD: begin
        v_nxt = acc_r[125:62];
        k_nxt = k_r + 1'b1;
        state_nxt = S_WBIT;
      end
      S_WFIN: begin
        w_nxt = w_round[62:46];
        state_nxt = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      rret_r <= S_IDLE;
      wi_r <= '0;
      cnt_r <= '0;
      full_r <= 1'b0;
      up_r <= 1'b0;
      out_valid_r <= 1'b0;
      falloff_r <= lfum_pkg::FalloffReset;
      power_r <= lfum_pkg::PowerReset;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      rret_r <= rret_nxt;
      wi_r <= wi_nxt;
      cnt_r <= cnt_nxt;
      full_r <= full_nxt;
      up_r <= up_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lfum_pkg::CfgFalloff: falloff_r <= cfg_wdata;
          lfum_pkg::CfgPower:   power_r <= cfg_wdata[3:0];
          default:              power_r <= power_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    tot_r <= tot_nxt;
    age_r <= age_nxt;
    tr_r <= tr_nxt;
    s_r <= s_nxt;
    ws_r <= ws_nxt;
    wtot_r <= wtot_nxt;
    plain_r <= plain_nxt;
    wpow_r <= wpow_nxt;
    x_r <= x_nxt;
    metric_r <= metric_nxt;
    m_r <= m_nxt;
    p_r <= p_nxt;
    rd_addr_r <= rd_addr_nxt;
    q_r <= q_nxt;
    k_r <= k_nxt;
    pp_r <= pp_nxt;
    v_r <= v_nxt;
    acc_r <= acc_nxt;
    w_r <= w_nxt;
    out_r <= out_nxt;
  end

endmodule
